// File: design/bdph_pkg.sv
// Package for the button debounce block with press and hold detection.
// Holds the mode and event codes, configuration indexes and reset values.
// Depends on nothing; every design file refers to it by scoped names.
`default_nettype none

package bdph_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned EVENT_W = 2;
    localparam int unsigned CFG_IDX_W = 1;

    // Press state of the button.
    localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PRESSED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD    = 2'd2;

    // Event codes on the result word.
    localparam logic [EVENT_W-1:0] EVT_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EVT_SINGLE = 2'd1;
    localparam logic [EVENT_W-1:0] EVT_HOLD   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 1'b1;

    localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd50;
    localparam logic [TIME_W-1:0] HOLD_RESET     = 32'd1000;

    // Level of the active-low pin when released.
    localparam logic LEVEL_RELEASED = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] debounce_ticks;
        logic [TIME_W-1:0] hold_ticks;
    } t_cfg;

endpackage

`default_nettype wire

// File: design/bdph_cfg.sv
// Configuration register file of the button debounce block.
// Holds the debounce and hold thresholds; uses bdph_pkg.
`default_nettype none

module bdph_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic [bdph_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bdph_pkg::TIME_W-1:0]       i_cfg_data,
    output bdph_pkg::t_cfg                         o_cfg
);

    bdph_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= bdph_pkg::DEBOUNCE_RESET;
            r_cfg.hold_ticks     <= bdph_pkg::HOLD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bdph_pkg::CFG_DEBOUNCE: r_cfg.debounce_ticks <= i_cfg_data;
                bdph_pkg::CFG_HOLD:     r_cfg.hold_ticks     <= i_cfg_data;
                default:                r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: design/bdph_step.sv
// Debounce and press/hold state machine of the button debounce block.
// Holds the button state and computes one event per sample; uses bdph_pkg.
`default_nettype none

module bdph_step (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_fire,
    input  wire logic                              i_raw_level,
    input  wire logic [bdph_pkg::TIME_W-1:0]       i_time_now,
    input  wire bdph_pkg::t_cfg                    i_cfg,
    output logic [bdph_pkg::EVENT_W-1:0]           o_event_res
);

    logic                              r_previous_raw;
    logic [bdph_pkg::TIME_W-1:0]       r_change_stamp;
    logic                              r_stable_level;
    logic [bdph_pkg::TIME_W-1:0]       r_press_stamp;
    logic [bdph_pkg::MODE_W-1:0]       r_mode;

    logic                              n_stable_level;
    logic [bdph_pkg::TIME_W-1:0]       n_press_stamp;
    logic [bdph_pkg::MODE_W-1:0]       n_mode;
    logic [bdph_pkg::EVENT_W-1:0]      n_event;

    logic                              raw_same;
    logic [bdph_pkg::TIME_W-1:0]       settle_time;
    logic [bdph_pkg::TIME_W-1:0]       held_time;
    logic                              take_level;
    logic                              hold_due;

    // A level change restarts the settle time at zero, so a fresh change
    // can never be taken as stable in the same sample.
    assign raw_same    = (i_raw_level == r_previous_raw);
    assign settle_time = i_time_now - r_change_stamp;
    assign held_time   = i_time_now - r_press_stamp;
    assign take_level  = raw_same && (settle_time > i_cfg.debounce_ticks)
                         && (r_stable_level != i_raw_level);
    assign hold_due    = held_time > i_cfg.hold_ticks;

    always_comb begin
        n_stable_level = r_stable_level;
        n_press_stamp  = r_press_stamp;
        n_mode         = r_mode;
        n_event        = bdph_pkg::EVT_NONE;
        if (take_level) begin
            n_stable_level = i_raw_level;
            if (i_raw_level != bdph_pkg::LEVEL_RELEASED) begin
                // A new press starts its hold time at zero: no hold event now.
                n_press_stamp = i_time_now;
                n_mode        = bdph_pkg::MODE_PRESSED;
            end else if (r_mode == bdph_pkg::MODE_HOLD) begin
                n_mode = bdph_pkg::MODE_IDLE;
            end else if (r_mode == bdph_pkg::MODE_PRESSED) begin
                n_mode  = bdph_pkg::MODE_IDLE;
                n_event = bdph_pkg::EVT_SINGLE;
            end
        end else if (r_mode == bdph_pkg::MODE_PRESSED && hold_due) begin
            n_mode  = bdph_pkg::MODE_HOLD;
            n_event = bdph_pkg::EVT_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_previous_raw <= bdph_pkg::LEVEL_RELEASED;
            r_change_stamp <= '0;
            r_stable_level <= bdph_pkg::LEVEL_RELEASED;
            r_press_stamp  <= '0;
            r_mode         <= bdph_pkg::MODE_IDLE;
        end else if (i_fire) begin
            if (!raw_same) begin
                r_change_stamp <= i_time_now;
            end
            r_previous_raw <= i_raw_level;
            r_stable_level <= n_stable_level;
            r_press_stamp  <= n_press_stamp;
            r_mode         <= n_mode;
        end
    end

    assign o_event_res = n_event;

endmodule

`default_nettype wire

// File: design/button_debounce_press_hold.sv
// Top level of the button debounce block with single-press and hold events.
// Instantiates bdph_cfg and bdph_step; uses bdph_pkg.
//
// Usage: each input word carries one sample of the active-low button pin
// (i_raw_level) and the tick timestamp of that sample (i_time_now). For every
// accepted input word exactly one output word comes out, in order, carrying
// o_event_res: none, single press released, or hold reached.
// Both channels use valid/ready; a word moves when valid and ready are both
// high at a rising edge. Configuration words arrive on their own channel
// (index 0 debounce ticks, index 1 hold ticks); that channel is always ready
// and should be used only while no sample is in flight.
// An accepted input word is first held in the input register; then the
// debounce and hold compares write the output register and raise output
// valid, and the event word can be taken from there. Throughput is one word
// per cycle while the receiver keeps ready high, with a single state update
// of the press/hold logic per cycle.
// When the receiver stalls, the output register holds its word, the input
// register keeps at most one more, and then input ready drops.
// Synchronous active-low reset empties both registers, restores the default
// thresholds (50 and 1000 ticks) and returns the button to released, idle.
`default_nettype none

module button_debounce_press_hold (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Sample channel.
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_raw_level,
    input  wire logic [bdph_pkg::TIME_W-1:0]       i_time_now,
    // Event channel.
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [bdph_pkg::EVENT_W-1:0]           o_event_res,
    // Configuration channel.
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [bdph_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bdph_pkg::TIME_W-1:0]       i_cfg_data
);

    logic                              r_in_valid;
    logic                              r_in_raw;
    logic [bdph_pkg::TIME_W-1:0]       r_in_time;
    logic                              r_out_valid;
    logic [bdph_pkg::EVENT_W-1:0]      r_event_res;

    logic                              advance;
    logic                              in_take;
    logic [bdph_pkg::EVENT_W-1:0]      step_event;
    bdph_pkg::t_cfg                    cfg;

    // The held sample is processed whenever the output register is free or
    // is being emptied in this same cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    bdph_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bdph_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_raw_level (r_in_raw),
        .i_time_now  (r_in_time),
        .i_cfg       (cfg),
        .o_event_res (step_event)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_raw  <= i_raw_level;
            r_in_time <= i_time_now;
        end
        if (advance) begin
            r_event_res <= step_event;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_event_res;

endmodule

`default_nettype wire
